// ===== hw/rtl/dtep_pkg.sv =====
package dtep_pkg;

  // Request codes carried in req_type.
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2
  } req_type_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_DTMF_ENABLED  = 2'd0,
    CFG_FRAME_SAMPLES = 2'd1,
    CFG_EVENT_PT      = 2'd2
  } cfg_index_t;

  localparam int unsigned STOP_REPEATS_DEF = 3;

  localparam logic [12:0] FRAME_SAMPLES_RST = 13'd80;
  localparam logic [6:0]  EVENT_PT_RST      = 7'd101;
  localparam logic [15:0] DUR_MAX           = 16'hFFFF;
  localparam logic [5:0]  VOLUME_DBM0       = 6'd10;

  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_D  = 8'h64;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_D  = 8'h44;
  localparam logic [3:0] EV_STAR    = 4'd10;
  localparam logic [3:0] EV_HASH    = 4'd11;
  localparam logic [3:0] EV_LETTER  = 4'd12;

  // One accepted input transaction.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  tone_code;
    logic [31:0] now_timestamp;
  } item_t;

  // One event packet.
  typedef struct packed {
    logic [3:0]  event_code;
    logic        end_flag;
    logic [5:0]  volume;
    logic [15:0] duration;
    logic        marker;
    logic [31:0] start_timestamp;
    logic [6:0]  payload_type;
  } pkt_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] ev;
  } tone_map_t;

  // Maps a raw tone code to a telephone event number.
  function automatic tone_map_t map_tone(input logic [7:0] code);
    tone_map_t res;
    res.ok = 1'b1;
    res.ev = 4'd0;
    if (code <= 8'd9) begin
      res.ev = code[3:0];
    end else if (code >= CHAR_0 && code <= CHAR_9) begin
      res.ev = code[3:0];
    end else if ((code >= CHAR_LC_A && code <= CHAR_LC_D) ||
                 (code >= CHAR_UC_A && code <= CHAR_UC_D)) begin
      res.ev = code[3:0] - 4'd1 + EV_LETTER;
    end else if (code == CHAR_STAR) begin
      res.ev = EV_STAR;
    end else if (code == CHAR_HASH) begin
      res.ev = EV_HASH;
    end else begin
      res.ok = 1'b0;
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/dtmf_event_packetizer.sv =====
// Telephone-event (DTMF) packetizer. Each input transaction is a frame tick
// carrying the current RTP timestamp, a start-tone request with a raw tone
// code, or a stop-tone request; a tick may produce one event packet on the
// result channel. The block takes one transaction per clock cycle while the
// result side keeps up: a transaction is held in the input register, then
// the packet decision and all state updates happen in a single pass and
// the packet lands in the result register, which offers it on the result
// channel; a stall can hold the tick in the input register before that.
// The result register decides the rate: when it holds an untaken packet and
// the result side stalls, the transaction in the input register cannot move
// on, and once that register is occupied the input side stalls as well.
// Starts, stops and ticks without a packet also wait for room in the result
// register before they are processed.
// Configuration writes are always ready and take effect at once; write them
// only while no transaction is in flight.
module dtmf_event_packetizer #(
  parameter int unsigned STOP_REPEATS = dtep_pkg::STOP_REPEATS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  // Input transaction channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_tone_code,
  input  logic [31:0] in_now_timestamp,

  // Event packet channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_event_code,
  output logic        out_end_flag,
  output logic [5:0]  out_volume,
  output logic [15:0] out_duration,
  output logic        out_marker,
  output logic [31:0] out_start_timestamp,
  output logic [6:0]  out_payload_type,

  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata
);

  // Configuration registers.
  logic        dtmf_enabled_r;
  logic [12:0] frame_samples_r;
  logic [6:0]  event_pt_r;

  dtep_pkg::item_t in_item;
  dtep_pkg::item_t item;
  dtep_pkg::pkt_t  pkt;
  dtep_pkg::pkt_t  pkt_q;
  logic            room;
  logic            go;
  logic            emit;

  assign cfg_ready = 1'b1;

  // Writes to an index beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dtmf_enabled_r  <= 1'b0;
      frame_samples_r <= dtep_pkg::FRAME_SAMPLES_RST;
      event_pt_r      <= dtep_pkg::EVENT_PT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dtep_pkg::CFG_DTMF_ENABLED:  dtmf_enabled_r  <= cfg_wdata[0];
        dtep_pkg::CFG_FRAME_SAMPLES: frame_samples_r <= cfg_wdata;
        dtep_pkg::CFG_EVENT_PT:      event_pt_r      <= cfg_wdata[6:0];
        default: begin
        end
      endcase
    end
  end

  assign in_item.req_type      = in_req_type;
  assign in_item.tone_code     = in_tone_code;
  assign in_item.now_timestamp = in_now_timestamp;

  dtep_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .room     (room),
    .go       (go),
    .item     (item)
  );

  // Tone state and the per-tick packet decision.
  dtep_engine #(
    .STOP_REPEATS (STOP_REPEATS)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (go),
    .item          (item),
    .dtmf_enabled  (dtmf_enabled_r),
    .frame_samples (frame_samples_r),
    .event_pt      (event_pt_r),
    .emit          (emit),
    .pkt           (pkt)
  );

  dtep_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (go && emit),
    .pkt_in    (pkt),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pkt_out   (pkt_q)
  );

  assign out_event_code      = pkt_q.event_code;
  assign out_end_flag        = pkt_q.end_flag;
  assign out_volume          = pkt_q.volume;
  assign out_duration        = pkt_q.duration;
  assign out_marker          = pkt_q.marker;
  assign out_start_timestamp = pkt_q.start_timestamp;
  assign out_payload_type    = pkt_q.payload_type;

endmodule

// ===== hw/rtl/dtep_in_reg.sv =====
module dtep_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dtep_pkg::item_t     in_item,
  input  logic                room,
  output logic                go,
  output dtep_pkg::item_t     item
);

  logic            vld_r;
  logic            vld_nxt;
  dtep_pkg::item_t item_r;
  logic            load;

  // The held item moves on when the result register has room.
  assign go       = vld_r && room;
  assign in_stall = vld_r && !room;
  assign load     = in_valid && !in_stall;
  assign vld_nxt  = load || (vld_r && !go);
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== hw/rtl/dtep_engine.sv =====
module dtep_engine #(
  parameter int unsigned STOP_REPEATS = dtep_pkg::STOP_REPEATS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  dtep_pkg::item_t  item,
  input  logic             dtmf_enabled,
  input  logic [12:0]      frame_samples,
  input  logic [6:0]       event_pt,
  output logic             emit,
  output dtep_pkg::pkt_t   pkt
);

  localparam int unsigned CW = $clog2(STOP_REPEATS + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(STOP_REPEATS);

  // A countdown of zero stands for "not ending".
  logic            active_r, active_nxt;
  logic            is_new_r, is_new_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [3:0]      event_r, event_nxt;
  logic [31:0]     start_ts_r, start_ts_nxt;
  logic [31:0]     last_ts_r, last_ts_nxt;
  logic [13:0]     interval_r, interval_nxt;
  logic [15:0]     total_r, total_nxt;

  dtep_pkg::tone_map_t tmap;
  logic [31:0]     start_eff;
  logic [13:0]     interval_eff;
  logic [CW-1:0]   cnt_eff;
  logic [31:0]     resend_at;
  logic [31:0]     dur_raw;
  logic [31:0]     total_raw;
  logic [15:0]     total_eff;
  logic [15:0]     dur_sat;

  assign tmap         = dtep_pkg::map_tone(item.tone_code);
  assign start_eff    = is_new_r ? item.now_timestamp : start_ts_r;
  assign interval_eff = is_new_r ? {frame_samples, 1'b0} : interval_r;
  assign cnt_eff      = is_new_r ? '0 : cnt_r;
  assign resend_at    = last_ts_r + {18'd0, interval_eff};
  assign dur_raw      = item.now_timestamp + {18'd0, interval_eff} - start_eff;
  assign total_raw    = item.now_timestamp - start_eff;
  assign total_eff    = (cnt_eff == CNT_FULL) ?
                        ((|total_raw[31:16]) ? dtep_pkg::DUR_MAX : total_raw[15:0]) :
                        total_r;
  assign dur_sat      = (|dur_raw[31:16]) ? dtep_pkg::DUR_MAX : dur_raw[15:0];

  always_comb begin
    active_nxt   = active_r;
    is_new_nxt   = is_new_r;
    cnt_nxt      = cnt_r;
    event_nxt    = event_r;
    start_ts_nxt = start_ts_r;
    last_ts_nxt  = last_ts_r;
    interval_nxt = interval_r;
    total_nxt    = total_r;
    emit         = 1'b0;

    pkt.event_code      = event_r;
    pkt.end_flag        = 1'b0;
    pkt.volume          = dtep_pkg::VOLUME_DBM0;
    pkt.duration        = dur_sat;
    pkt.marker          = is_new_r;
    pkt.start_timestamp = start_eff;
    pkt.payload_type    = event_pt;

    if (go) begin
      case (item.req_type)
        dtep_pkg::REQ_START: begin
          if (dtmf_enabled && !active_r && cnt_r == '0 && tmap.ok) begin
            active_nxt = 1'b1;
            event_nxt  = tmap.ev;
            is_new_nxt = 1'b1;
          end
        end
        dtep_pkg::REQ_STOP: begin
          if (active_r && cnt_r == '0) begin
            cnt_nxt = CNT_FULL;
          end
        end
        dtep_pkg::REQ_TICK: begin
          if (active_r && dtmf_enabled) begin
            start_ts_nxt = start_eff;
            interval_nxt = interval_eff;
            cnt_nxt      = cnt_eff;
            total_nxt    = total_eff;
            if (cnt_eff == '0) begin
              if (is_new_r || resend_at <= item.now_timestamp) begin
                emit        = 1'b1;
                last_ts_nxt = item.now_timestamp;
                is_new_nxt  = 1'b0;
              end
            end else begin
              // End packets repeat until the countdown runs out.
              emit         = 1'b1;
              pkt.end_flag = 1'b1;
              pkt.duration = total_eff;
              pkt.marker   = 1'b0;
              last_ts_nxt  = item.now_timestamp;
              cnt_nxt      = cnt_eff - CW'(1);
              if (cnt_eff == CW'(1)) begin
                active_nxt = 1'b0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      is_new_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      is_new_r <= is_new_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    event_r    <= event_nxt;
    start_ts_r <= start_ts_nxt;
    last_ts_r  <= last_ts_nxt;
    interval_r <= interval_nxt;
    total_r    <= total_nxt;
  end

endmodule

// ===== hw/rtl/dtep_out_reg.sv =====
module dtep_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  dtep_pkg::pkt_t  pkt_in,
  output logic            room,
  output logic            out_valid,
  input  logic            out_stall,
  output dtep_pkg::pkt_t  pkt_out
);

  logic           vld_r;
  logic           vld_nxt;
  dtep_pkg::pkt_t pkt_r;

  assign room      = !vld_r || !out_stall;
  assign vld_nxt   = load || (vld_r && out_stall);
  assign out_valid = vld_r;
  assign pkt_out   = pkt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pkt_r <= pkt_in;
    end
  end

endmodule
